FILE: sv/sofp_pkg.sv
`timescale 1ns / 1ps
// Package for the sphere overlap pair finder: field widths, defaults and op codes.
// No dependencies; compiled first.
package sofp_pkg;

	localparam int unsigned MAX_OBJECTS_DEF = 64;
	localparam int unsigned COORD_WIDTH_DEF = 16;
	localparam int unsigned RADIUS_WIDTH    = 16;
	localparam int unsigned INDEX_WIDTH     = 6;

	// Command op codes
	localparam logic OP_CLEAR = 1'b0;
	localparam logic OP_ADD   = 1'b1;

endpackage

FILE: sv/sofp_cmd_if.sv
`timescale 1ns / 1ps
// Channel interfaces: sphere commands in, overlap pairs out.
// Depends on sofp_pkg.
interface sofp_cmd_if #(
	parameter int unsigned COORD_WIDTH = sofp_pkg::COORD_WIDTH_DEF
);
	import sofp_pkg::*;

	logic                           valid;
	logic                           ready;
	logic                           op;
	logic signed [COORD_WIDTH-1:0]  center_x;
	logic signed [COORD_WIDTH-1:0]  center_y;
	logic signed [COORD_WIDTH-1:0]  center_z;
	logic        [RADIUS_WIDTH-1:0] sphere_radius;

	modport source (output valid, op, center_x, center_y, center_z, sphere_radius,
		input ready);
	modport sink (input valid, op, center_x, center_y, center_z, sphere_radius,
		output ready);
endinterface

interface sofp_pair_if;
	import sofp_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [INDEX_WIDTH-1:0] earlier_index;
	logic [INDEX_WIDTH-1:0] new_index;
	logic                   last_pair;

	modport source (output valid, earlier_index, new_index, last_pair, input ready);
	modport sink (input valid, earlier_index, new_index, last_pair, output ready);
endinterface

FILE: sv/sphere_overlap_pair_finder_top.sv
`timescale 1ns / 1ps
// Sphere overlap pair finder: stores bounding spheres and reports overlapping pairs.
// Depends on sofp_pkg and the channel interfaces in sofp_cmd_if.sv.
//
// A clear command empties the sphere set. An add command stores the sphere
// at index count and walks the stored spheres 0..count-1, testing each against the new
// one with one shared 17x17 squarer: dx^2+dy^2+dz^2 < (r_new+r_old)^2, strictly. Each
// stored sphere is passed over after the read and difference steps when an axis gap
// already reaches the radius sum, and otherwise goes through read, difference, four
// squaring steps and compare; a stalled output holds the compare and the final flush.
// Each overlap yields one pair (earlier_index, new_index) in ascending earlier_index
// order; the final pair of an add carries last_pair. Adds to a full set are dropped.
// The command channel is not ready while an add is in progress.
module sphere_overlap_pair_finder_top #(
	parameter int unsigned MAX_OBJECTS = sofp_pkg::MAX_OBJECTS_DEF,
	parameter int unsigned COORD_WIDTH = sofp_pkg::COORD_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	sofp_cmd_if.sink    cmd,
	sofp_pair_if.source rsp
);
	import sofp_pkg::*;

	localparam int unsigned IDX_W   = $clog2(MAX_OBJECTS);
	localparam int unsigned CNT_W   = $clog2(MAX_OBJECTS + 1);
	localparam int unsigned ENTRY_W = 3 * COORD_WIDTH + RADIUS_WIDTH;
	localparam int unsigned DIFF_W  = COORD_WIDTH + 1;
	localparam int unsigned RSUM_W  = RADIUS_WIDTH + 1;
	localparam int unsigned CMP_W   = (COORD_WIDTH > RSUM_W) ? COORD_WIDTH : RSUM_W;
	localparam int unsigned PROD_W  = 2 * RSUM_W;
	localparam int unsigned ACC_W   = PROD_W + 2;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_READ  = 3'd1;
	localparam logic [2:0] ST_DIFF  = 3'd2;
	localparam logic [2:0] ST_MUL   = 3'd3;
	localparam logic [2:0] ST_CMP   = 3'd4;
	localparam logic [2:0] ST_FLUSH = 3'd5;

	logic [2:0]              state_q;
	logic [CNT_W-1:0]        count_q;
	logic [IDX_W-1:0]        idx_q;
	logic [1:0]              step_q;
	logic                    pend_valid_q;
	logic [IDX_W-1:0]        pend_idx_q;
	logic                    rsp_valid_q;
	logic [INDEX_WIDTH-1:0]  earlier_q;
	logic [INDEX_WIDTH-1:0]  new_q;
	logic                    last_q;

	logic [ENTRY_W-1:0]      sphere_mem_q [MAX_OBJECTS];
	logic [ENTRY_W-1:0]      rd_data_q;
	logic [COORD_WIDTH-1:0]  coord_q [3];
	logic [RADIUS_WIDTH-1:0] radius_q;
	logic [RSUM_W-1:0]       d_q [3];
	logic [RSUM_W-1:0]       rsum_q;
	logic [PROD_W-1:0]       prod_q;
	logic [ACC_W-1:0]        acc_q;

	logic                    cmd_fire;
	logic                    slot_free;
	logic                    last_entry;
	logic                    full;
	logic                    pair_emit;
	logic [RSUM_W-1:0]       rsum;
	logic [RSUM_W-1:0]       d_trunc [3];
	logic [2:0]              axis_far;
	logic [RSUM_W-1:0]       mul_op;
	logic [PROD_W-1:0]       mul_res;
	logic                    hit;

	assign cmd.ready  = (state_q == ST_IDLE);
	assign cmd_fire   = cmd.valid && cmd.ready;
	assign slot_free  = !rsp_valid_q || rsp.ready;
	assign last_entry = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
	assign full       = (count_q == CNT_W'(MAX_OBJECTS));
	assign pair_emit  = pend_valid_q && slot_free
		&& ((state_q == ST_CMP && hit) || state_q == ST_FLUSH);

	assign rsp.valid         = rsp_valid_q;
	assign rsp.earlier_index = earlier_q;
	assign rsp.new_index     = new_q;
	assign rsp.last_pair     = last_q;

	// Store the new sphere on accept; read the entry under test every cycle
	always_ff @(posedge clk) begin
		if (cmd_fire && cmd.op == OP_ADD && !full) begin
			sphere_mem_q[count_q[IDX_W-1:0]] <= {cmd.center_z, cmd.center_y, cmd.center_x,
				cmd.sphere_radius};
		end
		rd_data_q <= sphere_mem_q[idx_q];
	end

	// Per-axis absolute differences against the stored center, and the radius sum
	assign rsum = RSUM_W'(radius_q) + RSUM_W'(rd_data_q[RADIUS_WIDTH-1:0]);

	for (genvar a = 0; a < 3; a++) begin : g_axis
		logic [COORD_WIDTH-1:0] mem_c;
		logic [DIFF_W-1:0]      diff;
		logic [DIFF_W-1:0]      mag;
		logic [CMP_W-1:0]       mag_ext;

		assign mem_c   = rd_data_q[RADIUS_WIDTH + a*COORD_WIDTH +: COORD_WIDTH];
		assign diff    = {coord_q[a][COORD_WIDTH-1], coord_q[a]}
			- {mem_c[COORD_WIDTH-1], mem_c};
		assign mag     = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;
		assign mag_ext = CMP_W'(mag[COORD_WIDTH-1:0]);
		assign axis_far[a] = (mag_ext >= CMP_W'(rsum));
		assign d_trunc[a]  = mag_ext[RSUM_W-1:0];
	end

	// Shared squarer: dx, dy, dz, then the radius sum
	always_comb begin
		case (step_q)
			2'd0:    mul_op = d_q[0];
			2'd1:    mul_op = d_q[1];
			2'd2:    mul_op = d_q[2];
			default: mul_op = rsum_q;
		endcase
	end
	assign mul_res = PROD_W'(mul_op * mul_op);
	assign hit     = (acc_q < ACC_W'(prod_q));

	// Datapath registers
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			coord_q[0] <= cmd.center_x;
			coord_q[1] <= cmd.center_y;
			coord_q[2] <= cmd.center_z;
			radius_q   <= cmd.sphere_radius;
		end
		if (state_q == ST_DIFF) begin
			d_q[0] <= d_trunc[0];
			d_q[1] <= d_trunc[1];
			d_q[2] <= d_trunc[2];
			rsum_q <= rsum;
		end
		if (state_q == ST_MUL) begin
			prod_q <= mul_res;
			if (step_q == 2'd0) begin
				acc_q <= '0;
			end else begin
				acc_q <= acc_q + ACC_W'(prod_q);
			end
		end
	end

	// Sequencer: walk stored spheres, hold one pending pair so the final one gets last_pair
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			idx_q        <= '0;
			step_q       <= '0;
			pend_valid_q <= 1'b0;
			pend_idx_q   <= '0;
			rsp_valid_q  <= 1'b0;
			earlier_q    <= '0;
			new_q        <= '0;
			last_q       <= 1'b0;
		end else begin
			// Load the output slot when a pair leaves; drop the transaction once taken
			if (pair_emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_fire) begin
						if (cmd.op == OP_CLEAR) begin
							count_q <= '0;
						end else if (!full) begin
							idx_q        <= '0;
							pend_valid_q <= 1'b0;
							state_q      <= (count_q == '0) ? ST_FLUSH : ST_READ;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_DIFF;
				end
				ST_DIFF: begin
					step_q <= '0;
					if (axis_far != 3'b000) begin
						if (last_entry) begin
							state_q <= ST_FLUSH;
						end else begin
							idx_q   <= idx_q + IDX_W'(1);
							state_q <= ST_READ;
						end
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					// Hold here while an older pending pair waits for the output slot
					if (!hit || !pend_valid_q || slot_free) begin
						if (hit) begin
							if (pend_valid_q) begin
								earlier_q   <= INDEX_WIDTH'(pend_idx_q);
								new_q       <= INDEX_WIDTH'(count_q);
								last_q      <= 1'b0;
							end
							pend_valid_q <= 1'b1;
							pend_idx_q   <= idx_q;
						end
						if (last_entry) begin
							state_q <= ST_FLUSH;
						end else begin
							idx_q   <= idx_q + IDX_W'(1);
							state_q <= ST_READ;
						end
					end
				end
				ST_FLUSH: begin
					if (!pend_valid_q || slot_free) begin
						if (pend_valid_q) begin
							earlier_q   <= INDEX_WIDTH'(pend_idx_q);
							new_q       <= INDEX_WIDTH'(count_q);
							last_q      <= 1'b1;
						end
						pend_valid_q <= 1'b0;
						count_q      <= count_q + CNT_W'(1);
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Checks on the sequencer
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_OBJECTS))
		else $error("sphere count exceeds capacity");

	a_pend_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> (state_q != ST_IDLE))
		else $error("pending pair left behind after an add");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ || state_q == ST_DIFF || state_q == ST_MUL || state_q == ST_CMP)
		|-> (CNT_W'(idx_q) < count_q))
		else $error("scan index beyond stored spheres");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.earlier_index < rsp.new_index))
		else $error("reported pair not ordered earlier before new");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for sphere_overlap_pair_finder_top: clear and add transactions in,
// overlap pairs out, each pair checked against a behavioral copy of the sphere set.
// Depends on sofp_pkg, the channel interfaces in sofp_cmd_if.sv and the RTL top.
module testbench;
	import sofp_pkg::*;

	localparam int unsigned CW           = COORD_WIDTH_DEF;
	localparam int unsigned MAX_SPHERES  = MAX_OBJECTS_DEF;
	localparam int unsigned ITEM_TARGET  = 500;
	// Drain margin for the longest add, in which every stored sphere is squared and compared
	localparam int unsigned DRAIN_CYCLES = 7 * MAX_SPHERES + 64;
	localparam longint unsigned CYCLE_LIMIT = 3_000_000;
	localparam int unsigned PRINT_CAP    = 200;

	typedef struct {
		logic                          op;
		logic signed [CW-1:0]          x;
		logic signed [CW-1:0]          y;
		logic signed [CW-1:0]          z;
		logic [RADIUS_WIDTH-1:0]       radius;
	} sphere_cmd_t;

	typedef struct {
		logic [INDEX_WIDTH-1:0] earlier;
		logic [INDEX_WIDTH-1:0] added;
		logic                   last;
	} overlap_pair_t;

	typedef enum int {RX_OPEN, RX_COIN, RX_ONE_IN_FOUR, RX_BURSTY} ready_pattern_t;

	logic clk = 1'b0;
	logic arst_n;

	sofp_cmd_if  #(.COORD_WIDTH(CW)) cmd_ch ();
	sofp_pair_if                     pair_ch ();

	sphere_overlap_pair_finder_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (pair_ch)
	);

	sphere_cmd_t    cmd_backlog[$];
	overlap_pair_t  pair_expect[$];
	sphere_cmd_t    known_sphere[MAX_SPHERES];
	int unsigned    known_count;
	int unsigned    items_queued;
	int unsigned    error_count;
	longint unsigned cycle_count;

	// 12 ns period clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Strict overlap: squared center distance below the squared radius sum
	function automatic bit strict_overlap(sphere_cmd_t a, sphere_cmd_t b);
		longint          pa[3];
		longint          pb[3];
		longint unsigned rsum;
		longint unsigned gap;
		longint unsigned acc;
		pa = '{longint'(a.x), longint'(a.y), longint'(a.z)};
		pb = '{longint'(b.x), longint'(b.y), longint'(b.z)};
		rsum = longint'(a.radius) + longint'(b.radius);
		acc = 0;
		for (int k = 0; k < 3; k++) begin
			gap = (pa[k] >= pb[k]) ? pa[k] - pb[k] : pb[k] - pa[k];
			if (gap >= rsum)
				return 1'b0;
			acc += gap * gap;
		end
		return acc < rsum * rsum;
	endfunction

	// Apply one accepted command to the sphere set and queue the pairs it yields
	task automatic find_overlaps(sphere_cmd_t c);
		overlap_pair_t found[$];
		overlap_pair_t p;
		if (c.op == OP_CLEAR) begin
			known_count = 0;
			return;
		end
		// drop adds to a full set
		if (known_count >= MAX_SPHERES)
			return;
		for (int unsigned slot = 0; slot < known_count; slot++) begin
			if (strict_overlap(c, known_sphere[slot])) begin
				p.earlier = slot[INDEX_WIDTH-1:0];
				p.added   = known_count[INDEX_WIDTH-1:0];
				p.last    = 1'b0;
				found = {found, p};
			end
		end
		if (found.size() > 0)
			found[found.size()-1].last = 1'b1;
		foreach (found[k])
			pair_expect = {pair_expect, found[k]};
		known_sphere[known_count] = c;
		known_count++;
	endtask

	task automatic queue_cmd(logic op, int x, int y, int z, int r);
		sphere_cmd_t c;
		c.op     = op;
		c.x      = x[CW-1:0];
		c.y      = y[CW-1:0];
		c.z      = z[CW-1:0];
		c.radius = r[RADIUS_WIDTH-1:0];
		cmd_backlog = {cmd_backlog, c};
		items_queued++;
	endtask

	// Queue a run of adds clustered around a random base so that many of them overlap
	task automatic queue_cluster(bit fresh, int adds, int scale);
		int span;
		int bx;
		int by;
		int bz;
		span = 1 << scale;
		bx = int'($urandom_range(0, 65535 - 2 * span)) - 32768 + span;
		by = int'($urandom_range(0, 65535 - 2 * span)) - 32768 + span;
		bz = int'($urandom_range(0, 65535 - 2 * span)) - 32768 + span;
		if (fresh)
			queue_cmd(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
		for (int k = 0; k < adds; k++) begin
			queue_cmd(OP_ADD,
				bx + int'($urandom_range(0, 2 * span)) - span,
				by + int'($urandom_range(0, 2 * span)) - span,
				bz + int'($urandom_range(0, 2 * span)) - span,
				$urandom_range(0, span));
		end
	endtask

	// Command driver: bursts of random length separated by random gaps
	int unsigned burst_left;
	int unsigned gap_left;
	sphere_cmd_t next_cmd;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
			burst_left = 0;
			gap_left   = 0;
		end else if (!cmd_ch.valid || cmd_ch.ready) begin
			if (gap_left > 0 || cmd_backlog.size() == 0) begin
				if (gap_left > 0)
					gap_left--;
				cmd_ch.valid <= 1'b0;
			end else begin
				next_cmd = cmd_backlog.pop_front();
				cmd_ch.op            <= next_cmd.op;
				cmd_ch.center_x      <= next_cmd.x;
				cmd_ch.center_y      <= next_cmd.y;
				cmd_ch.center_z      <= next_cmd.z;
				cmd_ch.sphere_radius <= next_cmd.radius;
				cmd_ch.valid         <= 1'b1;
				if (burst_left > 0)
					burst_left--;
				// start a new burst, often with no gap at all
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end
		end
	end

	// Pair receiver: switch at random between open, coin-flip, one-in-four and bursty stall patterns
	ready_pattern_t ready_pattern;
	int unsigned    pattern_left;
	int unsigned    stall_phase;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_ch.ready <= 1'b0;
			ready_pattern = RX_OPEN;
			pattern_left  = 0;
			stall_phase   = 0;
		end else begin
			if (pattern_left == 0) begin
				ready_pattern = ready_pattern_t'($urandom_range(0, 3));
				pattern_left  = $urandom_range(50, 400);
			end
			pattern_left--;
			stall_phase++;
			case (ready_pattern)
				RX_OPEN:        pair_ch.ready <= 1'b1;
				RX_COIN:        pair_ch.ready <= 1'($urandom_range(0, 1));
				RX_ONE_IN_FOUR: pair_ch.ready <= (stall_phase % 4 == 0);
				default:        pair_ch.ready <= (stall_phase % 7 < 5);
			endcase
		end
	end

	// Monitor: check pair transactions, then predict from command transactions
	overlap_pair_t got_pair;
	overlap_pair_t want_pair;
	sphere_cmd_t   seen_cmd;

	always @(posedge clk) begin
		if (arst_n) begin
			if (pair_ch.valid && pair_ch.ready) begin
				got_pair.earlier = pair_ch.earlier_index;
				got_pair.added   = pair_ch.new_index;
				got_pair.last    = pair_ch.last_pair;
				if (pair_expect.size() == 0) begin
					error_count++;
					if (error_count <= PRINT_CAP)
						$display("%0t: unexpected pair earlier=%0d new=%0d last=%0d, expected none",
							$time, got_pair.earlier, got_pair.added, got_pair.last);
				end else begin
					want_pair = pair_expect.pop_front();
					if (got_pair.earlier !== want_pair.earlier
							|| got_pair.added !== want_pair.added
							|| got_pair.last !== want_pair.last) begin
						error_count++;
						if (error_count <= PRINT_CAP)
							$display("%0t: pair mismatch: expected (%0d,%0d,%0d) actual (%0d,%0d,%0d)",
								$time, want_pair.earlier, want_pair.added, want_pair.last,
								got_pair.earlier, got_pair.added, got_pair.last);
					end
				end
			end
			if (cmd_ch.valid && cmd_ch.ready) begin
				seen_cmd.op     = cmd_ch.op;
				seen_cmd.x      = cmd_ch.center_x;
				seen_cmd.y      = cmd_ch.center_y;
				seen_cmd.z      = cmd_ch.center_z;
				seen_cmd.radius = cmd_ch.sphere_radius;
				find_overlaps(seen_cmd);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		arst_n               = 1'b0;
		cmd_ch.valid         = 1'b0;
		cmd_ch.op            = OP_CLEAR;
		cmd_ch.center_x      = '0;
		cmd_ch.center_y      = '0;
		cmd_ch.center_z      = '0;
		cmd_ch.sphere_radius = '0;
		pair_ch.ready        = 1'b0;
		known_count          = 0;
		items_queued         = 0;
		error_count          = 0;
		cycle_count          = 0;

		// Directed: clear, zero radii, touching spheres, coordinate and radius extremes
		queue_cmd(OP_CLEAR, 0, 0, 0, 0);
		queue_cmd(OP_ADD, 0, 0, 0, 0);
		queue_cmd(OP_ADD, 0, 0, 0, 0);
		queue_cmd(OP_ADD, 0, 0, 0, 1);
		// touching along one axis, then touching on a 3-4-5 diagonal
		queue_cmd(OP_ADD, 10, 0, 0, 9);
		queue_cmd(OP_ADD, 3, 4, 0, 4);
		queue_cmd(OP_ADD, -10, 0, 0, 10);
		queue_cmd(OP_CLEAR, -1, -1, -1, 65535);
		queue_cmd(OP_ADD, -32768, -32768, -32768, 65535);
		queue_cmd(OP_ADD, 32767, 32767, 32767, 65535);
		queue_cmd(OP_ADD, 32767, -32768, 0, 0);
		queue_cmd(OP_ADD, -32768, 32767, 32767, 0);
		queue_cmd(OP_ADD, 0, 0, 0, 65535);
		queue_cmd(OP_ADD, -1, -1, -1, 1);
		queue_cmd(OP_ADD, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
		queue_cmd(OP_CLEAR, 0, 0, 0, 0);
		queue_cmd(OP_CLEAR, 0, 0, 0, 0);
		queue_cmd(OP_ADD, 100, -100, 100, 200);

		// Fill the set past capacity with a tight cluster, then mix scenarios
		queue_cluster(1'b1, MAX_SPHERES + 4, 3);
		while (items_queued < ITEM_TARGET) begin
			int pick;
			pick = $urandom_range(0, 99);
			if (pick < 70)
				queue_cluster($urandom_range(0, 4) != 0, $urandom_range(1, 20),
					$urandom_range(0, 14));
			else if (pick < 72)
				queue_cluster(1'b1, MAX_SPHERES + $urandom_range(0, 3), $urandom_range(2, 6));
			else
				queue_cmd(($urandom_range(0, 7) == 0) ? OP_CLEAR : OP_ADD,
					$urandom, $urandom, $urandom, $urandom);
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: all commands sent, all pairs seen, then let a silent add finish
		@(negedge clk);
		while (cmd_backlog.size() != 0 || cmd_ch.valid || pair_expect.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: files.f
sv/sofp_pkg.sv
sv/sofp_cmd_if.sv
sv/sphere_overlap_pair_finder_top.sv
tb/testbench.sv
